// File: src/lobtob_pkg.sv
// Package for the top-of-book order store.
// Holds sizes, item and memory word types, codes and states; no dependencies.
package lobtob_pkg;

    localparam int ORDER_SLOTS  = 1024;
    localparam int PRICE_LEVELS = 1024;
    localparam int QTY_BITS     = 20;
    localparam int ID_BITS      = 64;
    localparam int PRICE_BITS   = 10;
    localparam int SIZE_BITS    = 30;
    localparam int SLOT_BITS    = $clog2(ORDER_SLOTS);
    localparam int LVL_BITS     = $clog2(PRICE_LEVELS);
    localparam int SWEEP_DEPTH  = (ORDER_SLOTS > PRICE_LEVELS) ? ORDER_SLOTS : PRICE_LEVELS;
    localparam int CNT_BITS     = $clog2(SWEEP_DEPTH) + 1;
    localparam int LIVE_BITS    = SLOT_BITS + 1;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_UPDATE = 2'd1,
        MODE_CANCEL = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_DUP       = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_APPLY_RD,
        S_APPLY_WR,
        S_BEST,
        S_OUT
    } t_state;

    typedef struct packed {
        t_mode                 mode;
        logic [ID_BITS-1:0]    ord_key;
        logic [PRICE_BITS-1:0] price_tick;
        logic [QTY_BITS-1:0]   quantity;
        logic                  is_buy;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        logic                  bid_valid;
        logic [PRICE_BITS-1:0] bid_price;
        logic [SIZE_BITS-1:0]  bid_size;
        logic                  ask_valid;
        logic [PRICE_BITS-1:0] ask_price;
        logic [SIZE_BITS-1:0]  ask_size;
    } t_out_item;

    typedef struct packed {
        logic                  valid;
        logic [ID_BITS-1:0]    id;
        logic                  side;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
    } t_slot_word;

    typedef struct packed {
        logic [SIZE_BITS-1:0] bid;
        logic [SIZE_BITS-1:0] ask;
    } t_lvl_word;

    typedef struct packed {
        logic [SIZE_BITS-1:0] cur;
        logic [QTY_BITS-1:0]  sub;
        logic [QTY_BITS-1:0]  add;
    } t_alu_req;

endpackage

// File: src/lobtob_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lobtob_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/lobtob_alu.sv
// Level size update unit: cur - sub + add.
// Depends on lobtob_pkg.
module lobtob_alu
    import lobtob_pkg::*;
(
    input  t_alu_req             i_req,
    output logic [SIZE_BITS-1:0] o_sum
);

    assign o_sum = i_req.cur - SIZE_BITS'(i_req.sub) + SIZE_BITS'(i_req.add);

endmodule

// File: src/limit_order_book_top_of_book.sv
// Top-of-book order store: slot search, level update and best price sweep.
// Depends on lobtob_pkg, lobtob_ram, lobtob_alu.
//
// One item at a time. After reset a clearing pass over SWEEP_DEPTH (1024)
// addresses runs before the first item is taken. Each item then searches
// the order store through its single read port, updates the price level in
// a read state and a write state, sweeps the level memory for best bid and
// ask, presents the result and returns to idle to take the next item; the
// result is held for as long as the output is stalled.
module limit_order_book_top_of_book
    import lobtob_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    t_state r_state, n_state;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    t_in_item             r_in, n_in;
    logic                 r_found, n_found;
    logic [SLOT_BITS-1:0] r_fslot, n_fslot;
    t_slot_word           r_fword, n_fword;
    logic                 r_free_found, n_free_found;
    logic [SLOT_BITS-1:0] r_free, n_free;
    t_status              r_status, n_status;
    logic                 r_op_ok, n_op_ok;
    logic [LIVE_BITS-1:0] r_live, n_live;
    logic                 r_bidv, n_bidv, r_askv, n_askv;
    logic [PRICE_BITS-1:0] r_bidp, n_bidp, r_askp, n_askp;
    logic [SIZE_BITS-1:0] r_bids, n_bids, r_asks, n_asks;

    logic                 s_we, l_we;
    logic [SLOT_BITS-1:0] s_waddr, s_raddr;
    t_slot_word           s_wdata, s_rdata;
    logic [LVL_BITS-1:0]  l_waddr, l_raddr;
    t_lvl_word            l_wdata, l_rdata;

    logic                  in_acc;
    logic                  sweep_end;
    logic [CNT_BITS-1:0]   prev_cnt;
    logic [PRICE_BITS-1:0] tgt_price;
    logic                  tgt_side;
    t_alu_req              alu_req;
    logic [SIZE_BITS-1:0]  alu_sum;

    lobtob_ram #(.W($bits(t_slot_word)), .D(ORDER_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    lobtob_ram #(.W($bits(t_lvl_word)), .D(PRICE_LEVELS)) u_lvl_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    lobtob_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    assign in_acc    = i_valid && !o_stall;
    assign prev_cnt  = r_cnt - CNT_BITS'(1);
    assign tgt_price = (r_in.mode == MODE_INSERT) ? r_in.price_tick : r_fword.price;
    assign tgt_side  = (r_in.mode == MODE_INSERT) ? r_in.is_buy : r_fword.side;

    always_comb begin
        alu_req.cur = tgt_side ? l_rdata.bid : l_rdata.ask;
        alu_req.sub = '0;
        alu_req.add = '0;
        case (r_in.mode)
            MODE_INSERT: alu_req.add = r_in.quantity;
            MODE_UPDATE: begin
                alu_req.sub = r_fword.qty;
                alu_req.add = r_in.quantity;
            end
            MODE_CANCEL: alu_req.sub = r_fword.qty;
            default: ;
        endcase
    end

    always_comb begin
        sweep_end = 1'b0;
        if (r_state == S_SCAN) begin
            sweep_end = (r_cnt == CNT_BITS'(ORDER_SLOTS));
        end else if (r_state == S_BEST) begin
            sweep_end = (r_cnt == CNT_BITS'(PRICE_LEVELS));
        end else if (r_state == S_CLEAR) begin
            sweep_end = (r_cnt == CNT_BITS'(SWEEP_DEPTH - 1));
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    if (sweep_end) n_state = S_IDLE;
            S_IDLE:     if (in_acc) n_state = S_SCAN;
            S_SCAN:     if (sweep_end) n_state = S_APPLY_RD;
            S_APPLY_RD: n_state = S_APPLY_WR;
            S_APPLY_WR: n_state = S_BEST;
            S_BEST:     if (sweep_end) n_state = S_OUT;
            S_OUT:      if (!i_stall) n_state = S_IDLE;
            default:    n_state = S_CLEAR;
        endcase
    end

    // memory controls and handshake
    always_comb begin
        o_stall = (r_state != S_IDLE);
        o_valid = (r_state == S_OUT);
        s_we    = 1'b0;
        s_waddr = r_cnt[SLOT_BITS-1:0];
        s_wdata = '0;
        s_raddr = r_cnt[SLOT_BITS-1:0];
        l_we    = 1'b0;
        l_waddr = r_cnt[LVL_BITS-1:0];
        l_wdata = '0;
        l_raddr = r_cnt[LVL_BITS-1:0];
        unique case (r_state)
            S_CLEAR: begin
                s_we = (r_cnt < CNT_BITS'(ORDER_SLOTS));
                l_we = (r_cnt < CNT_BITS'(PRICE_LEVELS));
            end
            S_APPLY_RD: l_raddr = LVL_BITS'(tgt_price);
            S_APPLY_WR: begin
                l_raddr = LVL_BITS'(tgt_price);
                l_waddr = LVL_BITS'(tgt_price);
                l_we    = r_op_ok;
                l_wdata = l_rdata;
                if (tgt_side) begin
                    l_wdata.bid = alu_sum;
                end else begin
                    l_wdata.ask = alu_sum;
                end
                s_we    = r_op_ok;
                s_waddr = (r_in.mode == MODE_INSERT) ? r_free : r_fslot;
                s_wdata.valid = (r_in.mode != MODE_CANCEL);
                s_wdata.id    = r_in.ord_key;
                s_wdata.side  = tgt_side;
                s_wdata.price = tgt_price;
                s_wdata.qty   = r_in.quantity;
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        n_cnt        = r_cnt;
        n_in         = r_in;
        n_found      = r_found;
        n_fslot      = r_fslot;
        n_fword      = r_fword;
        n_free_found = r_free_found;
        n_free       = r_free;
        n_status     = r_status;
        n_op_ok      = r_op_ok;
        n_live       = r_live;
        n_bidv       = r_bidv;
        n_bidp       = r_bidp;
        n_bids       = r_bids;
        n_askv       = r_askv;
        n_askp       = r_askp;
        n_asks       = r_asks;
        case (r_state)
            S_CLEAR: n_cnt = r_cnt + CNT_BITS'(1);
            S_IDLE: begin
                if (in_acc) begin
                    n_in         = i_item;
                    n_cnt        = '0;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                end
            end
            S_SCAN: begin
                if (r_cnt != '0) begin
                    if (s_rdata.valid && s_rdata.id == r_in.ord_key && !r_found) begin
                        n_found = 1'b1;
                        n_fslot = prev_cnt[SLOT_BITS-1:0];
                        n_fword = s_rdata;
                    end
                    if (!s_rdata.valid && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free       = prev_cnt[SLOT_BITS-1:0];
                    end
                end
                if (!sweep_end) begin
                    n_cnt = r_cnt + CNT_BITS'(1);
                end
            end
            S_APPLY_RD: begin
                n_status = ST_OK;
                n_op_ok  = 1'b0;
                case (r_in.mode) inside
                    MODE_INSERT: begin
                        if (r_found) begin
                            n_status = ST_DUP;
                        end else if (r_live >= LIVE_BITS'(ORDER_SLOTS) || !r_free_found) begin
                            n_status = ST_FULL;
                        end else begin
                            n_op_ok = 1'b1;
                        end
                    end
                    MODE_UPDATE, MODE_CANCEL: begin
                        if (r_found) begin
                            n_op_ok = 1'b1;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    default: ;
                endcase
            end
            S_APPLY_WR: begin
                if (r_op_ok && r_in.mode == MODE_INSERT) begin
                    n_live = r_live + LIVE_BITS'(1);
                end else if (r_op_ok && r_in.mode == MODE_CANCEL && r_live != '0) begin
                    n_live = r_live - LIVE_BITS'(1);
                end
                n_cnt  = '0;
                n_bidv = 1'b0;
                n_bidp = '0;
                n_bids = '0;
                n_askv = 1'b0;
                n_askp = '0;
                n_asks = '0;
            end
            S_BEST: begin
                if (r_cnt != '0) begin
                    if (l_rdata.bid != '0) begin
                        n_bidv = 1'b1;
                        n_bidp = PRICE_BITS'(prev_cnt);
                        n_bids = l_rdata.bid;
                    end
                    if (l_rdata.ask != '0 && !r_askv) begin
                        n_askv = 1'b1;
                        n_askp = PRICE_BITS'(prev_cnt);
                        n_asks = l_rdata.ask;
                    end
                end
                if (!sweep_end) begin
                    n_cnt = r_cnt + CNT_BITS'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_live  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_live  <= n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in         <= n_in;
        r_found      <= n_found;
        r_fslot      <= n_fslot;
        r_fword      <= n_fword;
        r_free_found <= n_free_found;
        r_free       <= n_free;
        r_status     <= n_status;
        r_op_ok      <= n_op_ok;
        r_bidv       <= n_bidv;
        r_bidp       <= n_bidp;
        r_bids       <= n_bids;
        r_askv       <= n_askv;
        r_askp       <= n_askp;
        r_asks       <= n_asks;
    end

    always_comb begin
        o_item.status    = r_status;
        o_item.bid_valid = r_bidv;
        o_item.bid_price = r_bidp;
        o_item.bid_size  = r_bids;
        o_item.ask_valid = r_askv;
        o_item.ask_price = r_askp;
        o_item.ask_size  = r_asks;
    end

`ifndef SYNTHESIS
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= LIVE_BITS'(ORDER_SLOTS))
        else $error("live order count above capacity");

    a_insert_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY_WR && r_op_ok && r_in.mode == MODE_INSERT) |-> r_free_found)
        else $error("insert without a free slot");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SCAN && r_cnt == '0))
        else $error("accepted item did not start slot search");

    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY_WR && r_op_ok) |-> (r_status == ST_OK))
        else $error("store change with failing status");
`endif

endmodule
